// File: rtl/mtsk_pkg.sv
// Shared types and constants for the mesh time sync keeper.
// No dependencies; every module of the block refers to this package.
`timescale 1ns / 1ps

package mtsk_pkg;

    localparam int unsigned TICKS_PER_SECOND = 32768;
    localparam int unsigned MINUTE_SECONDS   = 60;

    localparam int unsigned IN_TDATA_W  = 144;
    localparam int unsigned IN_TUSER_W  = 3;
    localparam int unsigned OUT_TDATA_W = 216;

    // Offset in seconds: 16-bit minutes times sixty fits in 23 signed bits.
    localparam int unsigned SECS_W = 23;

    typedef enum logic [2:0] {
        FUNC_ADD_TICKS  = 3'd0,
        FUNC_MASTER_SET = 3'd1,
        FUNC_MESH_SYNC  = 3'd2,
        FUNC_NET_SYNC   = 3'd3,
        FUNC_CORRECTION = 3'd4,
        FUNC_QUERY      = 3'd5
    } t_func;

    typedef struct packed {
        logic [2:0]         func;
        logic [31:0]        seconds_stamp;
        logic [31:0]        elapsed_stamp;
        logic [31:0]        extra_ticks;
        logic signed [15:0] zone_offset_minutes;
        logic [31:0]        remote_counter;
    } t_item;

    typedef struct packed {
        logic [31:0]        base_seconds;
        logic [31:0]        elapsed_seconds;
        logic [31:0]        subsecond_ticks;
        logic signed [15:0] zone_offset;
        logic [31:0]        counter;
        logic               master;
        logic               awaiting;
        logic               seen;
        logic               accepted;
        logic               synced_event;
    } t_snap;

endpackage

// File: rtl/mtsk_in_stage.sv
// Input register of the mesh time sync keeper: unpacks and holds one event.
// Depends on mtsk_pkg.
`timescale 1ns / 1ps

module mtsk_in_stage (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [mtsk_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    input  logic [mtsk_pkg::IN_TUSER_W-1:0]      s_axis_tuser,
    output logic                                 o_valid,
    output mtsk_pkg::t_item                      o_item,
    input  logic                                 i_take
);

    logic            r_valid;
    mtsk_pkg::t_item r_item;
    mtsk_pkg::t_item n_item;
    logic            w_accept;

    assign s_axis_tready = !r_valid || i_take;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_item.func                = s_axis_tuser;
        n_item.seconds_stamp       = s_axis_tdata[31:0];
        n_item.elapsed_stamp       = s_axis_tdata[63:32];
        n_item.extra_ticks         = s_axis_tdata[95:64];
        n_item.zone_offset_minutes = s_axis_tdata[111:96];
        n_item.remote_counter      = s_axis_tdata[143:112];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// File: rtl/mtsk_state.sv
// Time keeping state: applies one event per cycle while its output is taken, and folds whole seconds.
// Depends on mtsk_pkg.
`timescale 1ns / 1ps

module mtsk_state (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_wr_en,
    input  logic            i_cfg_wr_data,
    input  logic            i_valid,
    input  mtsk_pkg::t_item i_item,
    output logic            o_take,
    output logic            o_valid,
    output mtsk_pkg::t_snap o_snap,
    input  logic            i_take
);

    logic               r_device_is_asset;
    logic               r_valid;
    logic [31:0]        r_base;
    logic [31:0]        r_elapsed;
    logic [31:0]        r_ticks;
    logic signed [15:0] r_offset;
    logic [31:0]        r_counter;
    logic               r_master;
    logic               r_awaiting;
    logic               r_seen;
    logic               r_accepted;
    logic               r_synced_event;

    logic [31:0]        n_base;
    logic [31:0]        n_elapsed;
    logic [31:0]        n_ticks;
    logic signed [15:0] n_offset;
    logic [31:0]        n_counter;
    logic               n_master;
    logic               n_awaiting;
    logic               n_seen;
    logic               n_accepted;
    logic               n_synced_event;

    logic [31:0]        w_elapsed_pre;
    logic [31:0]        w_ticks_pre;
    logic               w_move;

    assign w_move = i_valid && (!r_valid || i_take);
    assign o_take = w_move;

    always_comb begin
        n_base         = r_base;
        w_elapsed_pre  = r_elapsed;
        w_ticks_pre    = r_ticks;
        n_offset       = r_offset;
        n_counter      = r_counter;
        n_master       = r_master;
        n_awaiting     = r_awaiting;
        n_seen         = r_seen;
        n_accepted     = 1'b0;
        n_synced_event = 1'b0;
        unique case (i_item.func)
            mtsk_pkg::FUNC_ADD_TICKS: begin
                w_ticks_pre = r_ticks + i_item.extra_ticks;
                n_accepted  = 1'b1;
            end
            mtsk_pkg::FUNC_MASTER_SET: begin
                n_base        = i_item.seconds_stamp;
                w_elapsed_pre = i_item.elapsed_stamp;
                w_ticks_pre   = i_item.extra_ticks;
                n_offset      = i_item.zone_offset_minutes;
                n_counter     = r_counter + 32'd1;
                n_awaiting    = 1'b0;
                n_seen        = 1'b1;
                n_master      = 1'b1;
                n_accepted    = 1'b1;
            end
            mtsk_pkg::FUNC_MESH_SYNC: begin
                if (i_item.remote_counter > r_counter) begin
                    n_base        = i_item.seconds_stamp;
                    w_elapsed_pre = i_item.elapsed_stamp;
                    w_ticks_pre   = i_item.extra_ticks;
                    n_offset      = i_item.zone_offset_minutes;
                    n_counter     = i_item.remote_counter;
                    n_awaiting    = 1'b1;
                    n_seen        = 1'b0;
                    n_master      = 1'b0;
                    n_accepted    = 1'b1;
                end
            end
            mtsk_pkg::FUNC_NET_SYNC: begin
                if (r_counter == 32'd0 || r_device_is_asset) begin
                    n_base        = i_item.seconds_stamp;
                    w_elapsed_pre = i_item.elapsed_stamp;
                    w_ticks_pre   = i_item.extra_ticks;
                    n_offset      = i_item.zone_offset_minutes;
                    n_counter     = r_counter + 32'd1;
                    n_awaiting    = 1'b0;
                    n_seen        = 1'b0;
                    n_master      = 1'b0;
                    n_accepted    = 1'b1;
                end
            end
            mtsk_pkg::FUNC_CORRECTION: begin
                if (r_awaiting) begin
                    w_ticks_pre    = r_ticks + i_item.extra_ticks;
                    n_awaiting     = 1'b0;
                    n_seen         = 1'b1;
                    n_accepted     = 1'b1;
                    n_synced_event = 1'b1;
                end
            end
            default: begin
            end
        endcase
        // The tick rate is a power of two, so the fold is a shift and a mask.
        n_elapsed = w_elapsed_pre + 32'(w_ticks_pre / mtsk_pkg::TICKS_PER_SECOND);
        n_ticks   = 32'(w_ticks_pre % mtsk_pkg::TICKS_PER_SECOND);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_is_asset <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_device_is_asset <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid        <= 1'b0;
            r_base         <= '0;
            r_elapsed      <= '0;
            r_ticks        <= '0;
            r_offset       <= '0;
            r_counter      <= '0;
            r_master       <= 1'b0;
            r_awaiting     <= 1'b0;
            r_seen         <= 1'b0;
            r_accepted     <= 1'b0;
            r_synced_event <= 1'b0;
        end else if (w_move) begin
            r_valid        <= 1'b1;
            r_base         <= n_base;
            r_elapsed      <= n_elapsed;
            r_ticks        <= n_ticks;
            r_offset       <= n_offset;
            r_counter      <= n_counter;
            r_master       <= n_master;
            r_awaiting     <= n_awaiting;
            r_seen         <= n_seen;
            r_accepted     <= n_accepted;
            r_synced_event <= n_synced_event;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_comb begin
        o_snap.base_seconds    = r_base;
        o_snap.elapsed_seconds = r_elapsed;
        o_snap.subsecond_ticks = r_ticks;
        o_snap.zone_offset     = r_offset;
        o_snap.counter         = r_counter;
        o_snap.master          = r_master;
        o_snap.awaiting        = r_awaiting;
        o_snap.seen            = r_seen;
        o_snap.accepted        = r_accepted;
        o_snap.synced_event    = r_synced_event;
    end

    assign o_valid = r_valid;

    // A pending correction and a received one never coexist.
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_awaiting && r_seen))
        else $error("awaiting and seen flags both set");

    // The residue always holds less than one second after folding.
    a_ticks_folded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_move |=> (r_ticks < 32'(mtsk_pkg::TICKS_PER_SECOND)))
        else $error("tick residue not folded");

    // The state only changes when an event moves in.
    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_move |=> ($stable(r_counter) && $stable(r_base) && $stable(r_ticks)))
        else $error("state changed without an event");

    // A master set leaves the node master with no correction outstanding.
    a_master_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_move && i_item.func == mtsk_pkg::FUNC_MASTER_SET)
        |=> (r_master && r_seen && !r_awaiting && r_accepted))
        else $error("master set did not take effect");

    // A sync completion is always an accepted correction.
    a_synced_accepted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_synced_event) |-> r_accepted)
        else $error("sync completion without acceptance");

endmodule

// File: rtl/mtsk_out_stage.sv
// Result register: derives UTC and local time from the state snapshot and packs it.
// Depends on mtsk_pkg.
`timescale 1ns / 1ps

module mtsk_out_stage (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    input  mtsk_pkg::t_snap                      i_snap,
    output logic                                 o_take,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [mtsk_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

    logic                                r_valid;
    logic [mtsk_pkg::OUT_TDATA_W-1:0]    r_tdata;
    logic [mtsk_pkg::OUT_TDATA_W-1:0]    n_tdata;
    logic [31:0]                         w_utc;
    logic signed [mtsk_pkg::SECS_W-1:0]  w_secs;
    logic signed [33:0]                  w_sum;
    logic [31:0]                         w_local;
    logic                                w_synced;
    logic                                w_corrected;

    assign o_take = i_valid && (!r_valid || m_axis_tready);

    always_comb begin
        w_utc  = i_snap.base_seconds + i_snap.elapsed_seconds;
        w_secs = mtsk_pkg::SECS_W'(i_snap.zone_offset *
                 $signed(mtsk_pkg::SECS_W'(mtsk_pkg::MINUTE_SECONDS)));
        w_sum  = $signed({2'b00, w_utc}) + 34'(w_secs);
        // A negative sum means the offset would take local time below zero.
        w_local     = w_sum[33] ? w_utc : w_sum[31:0];
        w_synced    = (i_snap.base_seconds != 32'd0);
        w_corrected = w_synced && (i_snap.seen || !i_snap.awaiting);
        n_tdata = {3'b000,
                   i_snap.synced_event,
                   i_snap.master,
                   w_corrected,
                   w_synced,
                   i_snap.accepted,
                   i_snap.counter,
                   i_snap.zone_offset,
                   i_snap.subsecond_ticks,
                   i_snap.elapsed_seconds,
                   i_snap.base_seconds,
                   w_local,
                   w_utc};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_tdata <= n_tdata;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = r_tdata;

endmodule

// File: rtl/mesh_time_sync_keeper_top.sv
// Top level of the mesh time sync keeper: input register, time state, result register.
// Depends on mtsk_pkg, mtsk_in_stage, mtsk_state and mtsk_out_stage.
`timescale 1ns / 1ps
// Usage:
// Events arrive on the s_axis channel: tuser carries the event code and tdata the
// stamps, ticks, zone offset and remote counter. Each event yields exactly one
// result transaction on m_axis with UTC and local time, the stored state and the
// status flags. The device_is_asset setting is written through i_cfg_wr_en and
// i_cfg_wr_data while no event is in flight.
// An accepted event is loaded into the input register, then applied to the state
// register, then loaded into the result register, which drives m_axis_tvalid.
// Throughput is one event per cycle while the receiver keeps m_axis_tready high;
// the state update with its seconds fold is computed combinationally, so
// consecutive events never wait on each other.
// Reset (synchronous, active low) clears the time, offset, counter, all flags and
// the asset setting, and empties the pipeline.
// When the receiver stalls, the result register holds and the three stages fill
// up; s_axis_tready drops only once all three hold an event.

module mesh_time_sync_keeper_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wr_en,
    input  logic                                 i_cfg_wr_data,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // Fields from bit 0 up: seconds_stamp, elapsed_stamp, extra_ticks,
    // zone_offset_minutes, remote_counter.
    input  logic [mtsk_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // Fields from bit 0 up: func.
    input  logic [mtsk_pkg::IN_TUSER_W-1:0]      s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // Fields from bit 0 up: utc_seconds, local_seconds, base_seconds,
    // elapsed_seconds, subsecond_ticks, offset_out, counter_out, accepted,
    // time_synced, time_corrected, is_master, synced_event, then zero padding.
    output logic [mtsk_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

    logic            w_in_valid;
    mtsk_pkg::t_item w_item;
    logic            w_in_take;
    logic            w_st_valid;
    mtsk_pkg::t_snap w_snap;
    logic            w_st_take;

    mtsk_in_stage u_in_stage (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_valid       (w_in_valid),
        .o_item        (w_item),
        .i_take        (w_in_take)
    );

    mtsk_state u_state (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (w_in_valid),
        .i_item        (w_item),
        .o_take        (w_in_take),
        .o_valid       (w_st_valid),
        .o_snap        (w_snap),
        .i_take        (w_st_take)
    );

    mtsk_out_stage u_out_stage (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_st_valid),
        .i_snap        (w_snap),
        .o_take        (w_st_take),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

// File: sim/tb.sv
// Self-checking testbench for mesh_time_sync_keeper_top: directed events, then random ones.
// Depends on mtsk_pkg and the block's RTL; results are checked against a built-in time model.
`timescale 1ns / 1ps

module tb;

    localparam logic [2:0] FUNC_SPARE_6 = 3'd6;
    localparam logic [2:0] FUNC_SPARE_7 = 3'd7;
    localparam int         CLK_PERIOD   = 12;
    localparam int         PHASE_ITEMS  = 400;

    typedef struct packed {
        logic [31:0] utc;
        logic [31:0] local_secs;
        logic [31:0] base;
        logic [31:0] elapsed;
        logic [31:0] ticks;
        logic [15:0] offset;
        logic [31:0] counter;
        logic        accepted;
        logic        synced;
        logic        corrected;
        logic        master;
        logic        synced_evt;
    } t_time_report;

    typedef struct {
        mtsk_pkg::t_item it;
        bit              typed;
        t_time_report    want;
    } t_dir_row;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_cfg_wr_en;
    logic                             i_cfg_wr_data;
    logic                             s_axis_tvalid;
    logic                             s_axis_tready;
    logic [mtsk_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
    logic [mtsk_pkg::IN_TUSER_W-1:0]  s_axis_tuser;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready;
    logic [mtsk_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

    // Model copy of the keeper's state and of the asset setting.
    logic [31:0] clk_base;
    logic [31:0] clk_elapsed;
    logic [31:0] clk_residue;
    logic [15:0] clk_offset;
    logic [31:0] clk_generation;
    logic        clk_master;
    logic        clk_awaiting;
    logic        clk_corr_seen;
    logic        asset_mode;

    t_time_report expected_reports[$];
    t_dir_row     dir_rows[$];
    t_time_report got_report;
    t_time_report want_report;
    int           mismatch_count;
    int           rx_hold;
    bit           tx_calm;
    bit           rx_calm;

    mesh_time_sync_keeper_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    function automatic void load_clock(input mtsk_pkg::t_item it);
        clk_base    = it.seconds_stamp;
        clk_elapsed = it.elapsed_stamp;
        clk_residue = it.extra_ticks;
        clk_offset  = it.zone_offset_minutes;
    endfunction

    // Applies one event to the model state and returns the report it should produce.
    function automatic t_time_report predict_time_event(input mtsk_pkg::t_item it);
        t_time_report r;
        logic         acc;
        logic         evt;
        logic [31:0]  whole;
        int           offset_secs;
        acc = 1'b0;
        evt = 1'b0;
        case (it.func)
            mtsk_pkg::FUNC_ADD_TICKS: begin
                clk_residue = clk_residue + it.extra_ticks;
                acc = 1'b1;
            end
            mtsk_pkg::FUNC_MASTER_SET: begin
                load_clock(it);
                clk_generation = clk_generation + 32'd1;
                clk_awaiting   = 1'b0;
                clk_corr_seen  = 1'b1;
                clk_master     = 1'b1;
                acc = 1'b1;
            end
            mtsk_pkg::FUNC_MESH_SYNC: begin
                if (it.remote_counter > clk_generation) begin
                    load_clock(it);
                    clk_generation = it.remote_counter;
                    clk_awaiting   = 1'b1;
                    clk_corr_seen  = 1'b0;
                    clk_master     = 1'b0;
                    acc = 1'b1;
                end
            end
            mtsk_pkg::FUNC_NET_SYNC: begin
                if (clk_generation == 32'd0 || asset_mode) begin
                    load_clock(it);
                    clk_generation = clk_generation + 32'd1;
                    clk_awaiting   = 1'b0;
                    clk_corr_seen  = 1'b0;
                    clk_master     = 1'b0;
                    acc = 1'b1;
                end
            end
            mtsk_pkg::FUNC_CORRECTION: begin
                if (clk_awaiting) begin
                    clk_residue   = clk_residue + it.extra_ticks;
                    clk_awaiting  = 1'b0;
                    clk_corr_seen = 1'b1;
                    acc = 1'b1;
                    evt = 1'b1;
                end
            end
            default: ;
        endcase

        whole       = clk_residue / mtsk_pkg::TICKS_PER_SECOND;
        clk_elapsed = clk_elapsed + whole;
        clk_residue = clk_residue % mtsk_pkg::TICKS_PER_SECOND;

        r.utc = clk_base + clk_elapsed;
        offset_secs = int'($signed(clk_offset)) * int'(mtsk_pkg::MINUTE_SECONDS);
        // A negative offset larger than UTC itself leaves local time at UTC.
        if (offset_secs < 0 && r.utc < 32'(-offset_secs))
            r.local_secs = r.utc;
        else
            r.local_secs = r.utc + 32'(offset_secs);
        r.base       = clk_base;
        r.elapsed    = clk_elapsed;
        r.ticks      = clk_residue;
        r.offset     = clk_offset;
        r.counter    = clk_generation;
        r.accepted   = acc;
        r.synced     = (clk_base != 32'd0);
        r.corrected  = (clk_corr_seen || !clk_awaiting) && (clk_base != 32'd0);
        r.master     = clk_master;
        r.synced_evt = evt;
        return r;
    endfunction

    function automatic void dir_row(input logic [2:0] f, input logic [31:0] sec,
                                    input logic [31:0] el, input logic [31:0] tk,
                                    input logic [15:0] off, input logic [31:0] rc,
                                    input bit typed, input t_time_report want);
        t_dir_row row;
        row.it.func                = f;
        row.it.seconds_stamp       = sec;
        row.it.elapsed_stamp       = el;
        row.it.extra_ticks         = tk;
        row.it.zone_offset_minutes = off;
        row.it.remote_counter      = rc;
        row.typed = typed;
        row.want  = want;
        dir_rows.push_back(row);
    endfunction

    // Random event, biased towards sync messages that the current state will accept.
    function automatic mtsk_pkg::t_item draw_time_event();
        mtsk_pkg::t_item it;
        int              r;
        r = $urandom_range(0, 99);
        if (clk_awaiting && r < 35)
            it.func = mtsk_pkg::FUNC_CORRECTION;
        else if (r < 20)
            it.func = mtsk_pkg::FUNC_ADD_TICKS;
        else if (r < 32)
            it.func = mtsk_pkg::FUNC_MASTER_SET;
        else if (r < 55)
            it.func = mtsk_pkg::FUNC_MESH_SYNC;
        else if (r < 70)
            it.func = mtsk_pkg::FUNC_NET_SYNC;
        else if (r < 85)
            it.func = mtsk_pkg::FUNC_CORRECTION;
        else if (r < 93)
            it.func = mtsk_pkg::FUNC_QUERY;
        else
            it.func = $urandom_range(0, 1) ? FUNC_SPARE_6 : FUNC_SPARE_7;

        case ($urandom_range(0, 3))
            0:       it.seconds_stamp = 32'd0;
            1:       it.seconds_stamp = $urandom_range(0, 4000);
            default: it.seconds_stamp = $urandom;
        endcase
        case ($urandom_range(0, 2))
            0:       it.elapsed_stamp = $urandom_range(0, 4000);
            default: it.elapsed_stamp = $urandom;
        endcase
        case ($urandom_range(0, 3))
            0: it.extra_ticks = $urandom_range(0, 70000);
            1: it.extra_ticks = 32'($urandom_range(0, 8)) * mtsk_pkg::TICKS_PER_SECOND
                                + 32'($urandom_range(0, 1));
            2: it.extra_ticks = $urandom;
            default: it.extra_ticks = 32'hFFFF_FFFF - 32'($urandom_range(0, 100));
        endcase
        case ($urandom_range(0, 2))
            0:       it.zone_offset_minutes = 16'(-int'($urandom_range(0, 100)));
            1:       it.zone_offset_minutes = 16'($urandom_range(0, 100));
            default: it.zone_offset_minutes = 16'($urandom);
        endcase
        case ($urandom_range(0, 5))
            0, 1:    it.remote_counter = clk_generation + 32'($urandom_range(1, 3));
            2:       it.remote_counter = clk_generation;
            3:       it.remote_counter = $urandom;
            4:       it.remote_counter = $urandom_range(0, 20);
            default: it.remote_counter = 32'hFFFF_FFFF - 32'($urandom_range(0, 2));
        endcase
        return it;
    endfunction

    task automatic send_time_event(input mtsk_pkg::t_item it, input bit typed,
                                   input t_time_report want);
        t_time_report pred;
        int           gap;
        gap = tx_calm ? 0 : $urandom_range(0, 11);
        repeat (gap) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {it.remote_counter, it.zone_offset_minutes, it.extra_ticks,
                          it.elapsed_stamp, it.seconds_stamp};
        s_axis_tuser  <= it.func;
        do @(posedge i_clk); while (!s_axis_tready);
        pred = predict_time_event(it);
        expected_reports.push_back(typed ? want : pred);
    endtask

    task automatic drain_and_settle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge i_clk);
        // Three pipeline stages; let them settle before touching the setting.
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_asset_mode(input logic v);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        asset_mode = v;
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            mismatch_count++;
        end
    endfunction

    // Receiver side: a stall count is drawn for each result transaction.
    always @(negedge i_clk) begin
        if (rx_hold == 0) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_report.utc        = m_axis_tdata[31:0];
            got_report.local_secs = m_axis_tdata[63:32];
            got_report.base       = m_axis_tdata[95:64];
            got_report.elapsed    = m_axis_tdata[127:96];
            got_report.ticks      = m_axis_tdata[159:128];
            got_report.offset     = m_axis_tdata[175:160];
            got_report.counter    = m_axis_tdata[207:176];
            got_report.accepted   = m_axis_tdata[208];
            got_report.synced     = m_axis_tdata[209];
            got_report.corrected  = m_axis_tdata[210];
            got_report.master     = m_axis_tdata[211];
            got_report.synced_evt = m_axis_tdata[212];
            if (expected_reports.size() == 0) begin
                $error("result transaction with no event outstanding");
                mismatch_count++;
            end else begin
                want_report = expected_reports.pop_front();
                check_field("utc_seconds", want_report.utc, got_report.utc);
                check_field("local_seconds", want_report.local_secs, got_report.local_secs);
                check_field("base_seconds", want_report.base, got_report.base);
                check_field("elapsed_seconds", want_report.elapsed, got_report.elapsed);
                check_field("subsecond_ticks", want_report.ticks, got_report.ticks);
                check_field("offset_out", 32'(want_report.offset), 32'(got_report.offset));
                check_field("counter_out", want_report.counter, got_report.counter);
                check_field("accepted", 32'(want_report.accepted), 32'(got_report.accepted));
                check_field("time_synced", 32'(want_report.synced), 32'(got_report.synced));
                check_field("time_corrected", 32'(want_report.corrected),
                            32'(got_report.corrected));
                check_field("is_master", 32'(want_report.master), 32'(got_report.master));
                check_field("synced_event", 32'(want_report.synced_evt),
                            32'(got_report.synced_evt));
            end
            rx_hold <= rx_calm ? 0 : $urandom_range(0, 11);
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_wr_en    = 1'b0;
        i_cfg_wr_data  = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = '0;
        m_axis_tready  = 1'b0;
        rx_hold        = 0;
        tx_calm        = 1'b0;
        rx_calm        = 1'b0;
        mismatch_count = 0;
        clk_base       = '0;
        clk_elapsed    = '0;
        clk_residue    = '0;
        clk_offset     = '0;
        clk_generation = '0;
        clk_master     = 1'b0;
        clk_awaiting   = 1'b0;
        clk_corr_seen  = 1'b0;
        asset_mode     = 1'b0;

        // Straight after reset, and the unused codes, which act as a query.
        dir_row(mtsk_pkg::FUNC_QUERY, 0, 0, 0, 0, 0, 1, '0);
        dir_row(FUNC_SPARE_6, '1, '1, '1, '1, '1, 1, '0);
        dir_row(FUNC_SPARE_7, '1, '1, '1, '1, '1, 1, '0);
        // Three whole seconds fold into the elapsed count and five ticks remain.
        dir_row(mtsk_pkg::FUNC_ADD_TICKS, '1, '1, 32'd98309, '1, '1, 1,
                '{32'd3, 32'd3, 32'd0, 32'd3, 32'd5, 16'd0, 32'd0,
                  1'b1, 1'b0, 1'b0, 1'b0, 1'b0});
        dir_row(mtsk_pkg::FUNC_ADD_TICKS, 0, 0, '1, 0, 0, 0, '0);
        // Correction with nothing pending, and a mesh sync that is not newer.
        dir_row(mtsk_pkg::FUNC_CORRECTION, 0, 0, '1, 0, 0, 0, '0);
        dir_row(mtsk_pkg::FUNC_MESH_SYNC, 1, 1, 1, 1, 0, 0, '0);
        // Inter-network sync at counter zero with every field at its maximum but the zone offset, at its minimum.
        dir_row(mtsk_pkg::FUNC_NET_SYNC, '1, '1, '1, 16'h8000, '1, 1,
                '{32'h0001_FFFD, 32'h0001_FFFD, 32'hFFFF_FFFF, 32'h0001_FFFE,
                  32'h0000_7FFF, 16'h8000, 32'd1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0});
        dir_row(mtsk_pkg::FUNC_NET_SYNC, 7, 7, 7, 7, 7, 0, '0);
        dir_row(mtsk_pkg::FUNC_MESH_SYNC, 9, 9, 9, 9, 1, 0, '0);
        dir_row(mtsk_pkg::FUNC_MESH_SYNC, 1000, 0, 0, 16'h7FFF, '1, 0, '0);
        dir_row(mtsk_pkg::FUNC_QUERY, 0, 0, 0, 0, 0, 0, '0);
        dir_row(mtsk_pkg::FUNC_CORRECTION, 0, 0, '1, 0, 0, 0, '0);
        dir_row(mtsk_pkg::FUNC_CORRECTION, 0, 0, 5, 0, 0, 0, '0);
        // Master set from the top counter value wraps it to zero.
        dir_row(mtsk_pkg::FUNC_MASTER_SET, 100, 0, 0, 0, '1, 1,
                '{32'd100, 32'd100, 32'd100, 32'd0, 32'd0, 16'd0, 32'd0,
                  1'b1, 1'b1, 1'b1, 1'b1, 1'b0});
        dir_row(mtsk_pkg::FUNC_NET_SYNC, 5000, 7, 32'd32768, 0, 0, 0, '0);
        dir_row(mtsk_pkg::FUNC_MESH_SYNC, 0, 30, 0, 16'hFFFF, 5, 0, '0);
        // Negative offset exactly equal to UTC, then one second short of it.
        dir_row(mtsk_pkg::FUNC_MASTER_SET, 0, 60, 0, 16'hFFFF, 0, 1,
                '{32'd60, 32'd0, 32'd0, 32'd60, 32'd0, 16'hFFFF, 32'd6,
                  1'b1, 1'b0, 1'b0, 1'b1, 1'b0});
        dir_row(mtsk_pkg::FUNC_MASTER_SET, 0, 59, 0, 16'hFFFF, 0, 1,
                '{32'd59, 32'd59, 32'd0, 32'd59, 32'd0, 16'hFFFF, 32'd7,
                  1'b1, 1'b0, 1'b0, 1'b1, 1'b0});
        dir_row(mtsk_pkg::FUNC_MASTER_SET, '1, 1, 0, 16'h7FFF, 0, 0, '0);
        dir_row(mtsk_pkg::FUNC_ADD_TICKS, 0, 0, 32'd32767, 0, 0, 0, '0);
        dir_row(mtsk_pkg::FUNC_ADD_TICKS, 0, 0, 32'd1, 0, 0, 0, '0);
        dir_row(mtsk_pkg::FUNC_MASTER_SET, 0, 0, 0, 0, 0, 0, '0);

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k])
            send_time_event(dir_rows[k].it, dir_rows[k].typed, dir_rows[k].want);
        drain_and_settle();

        for (int phase = 0; phase < 4; phase++) begin
            write_asset_mode(phase % 2 == 0);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 50 == 0) begin
                    tx_calm = ($urandom_range(0, 3) == 0);
                    rx_calm = ($urandom_range(0, 3) == 0);
                end
                send_time_event(draw_time_event(), 1'b0, '0);
            end
            drain_and_settle();
        end

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: mesh_time_sync_keeper_top.f
rtl/mtsk_pkg.sv
rtl/mtsk_in_stage.sv
rtl/mtsk_state.sv
rtl/mtsk_out_stage.sv
rtl/mesh_time_sync_keeper_top.sv
sim/tb.sv
